// ----- rtl/core/chb_pkg.sv -----
// ----------------------------------------------------------------------------
// chb_pkg
// Shared types of the chained hash table: queue beats and the back FSM states.
// ----------------------------------------------------------------------------
package chb_pkg;

	localparam int KEY_W  = 31;
	localparam int CFG_W  = 5;
	localparam int BIDX_W = 4;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_SEARCH = 1'b1
	} op_t;

	// beat from the front to the back: key with its remainder already worked out
	typedef struct packed {
		op_t              op;
		logic [KEY_W-1:0] key;
		logic [CFG_W-1:0] rem;
	} work_t;

	typedef struct packed {
		logic              found;
		logic              status;
		logic [BIDX_W-1:0] bidx;
	} result_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_HEAD,
		B_WALK,
		B_DONE
	} back_state_t;

endpackage

// ----- rtl/core/chained_hash_table.sv -----
// Flow: the front accepts a beat, runs four 8-bit remainder steps and hands it off,
// then the back links an insert, or walks a search through the L chain nodes it visits.
// The front takes a new beat only once the last is handed off; the back walks
// one node per node-RAM read.
// Reset: bucket heads read empty at once through per-bucket valid flops,
// the node pool is never cleared, bucket_count returns to 10.
// ----------------------------------------------------------------------------
// chained_hash_table
// Separate-chaining hash table over a bounded node pool, modulo bucket hash.
// ----------------------------------------------------------------------------
module chained_hash_table import chb_pkg::*; #(
	parameter int MAX_BUCKETS  = 16,
	parameter int POOL_ENTRIES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              operation,
	input  logic [KEY_W-1:0]  key,
	output logic              empty,
	input  logic              pop,
	output logic              found,
	output logic              status,
	output logic [BIDX_W-1:0] bucket_index,
	input  logic              bucket_count_we,
	input  logic [CFG_W-1:0]  bucket_count
);

	logic [CFG_W-1:0] bucket_count_q;
	logic             wq_wr;
	work_t            wq_wdata;
	logic             wq_full;
	logic             wq_rd;
	work_t            wq_rdata;
	logic             wq_empty;
	logic             rq_wr;
	result_t          rq_wdata;
	logic             rq_full;
	result_t          rq_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= CFG_W'(10);
		end else if (bucket_count_we) begin
			bucket_count_q <= bucket_count;
		end
	end

	chb_front #(
		.MAX_BUCKETS (MAX_BUCKETS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.operation    (op_t'(operation)),
		.key          (key),
		.bucket_count (bucket_count_q),
		.wq_wr        (wq_wr),
		.wq_data      (wq_wdata),
		.wq_full      (wq_full)
	);

	chb_fifo #(
		.WIDTH ($bits(work_t))
	) u_work_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wq_wr),
		.wdata  (wq_wdata),
		.full   (wq_full),
		.rd     (wq_rd),
		.rdata  (wq_rdata),
		.empty  (wq_empty)
	);

	chb_back #(
		.MAX_BUCKETS  (MAX_BUCKETS),
		.POOL_ENTRIES (POOL_ENTRIES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.wq_data  (wq_rdata),
		.wq_empty (wq_empty),
		.wq_rd    (wq_rd),
		.rq_wr    (rq_wr),
		.rq_data  (rq_wdata),
		.rq_full  (rq_full)
	);

	chb_fifo #(
		.WIDTH ($bits(result_t))
	) u_result_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (rq_wr),
		.wdata  (rq_wdata),
		.full   (rq_full),
		.rd     (pop),
		.rdata  (rq_rdata),
		.empty  (empty)
	);

	assign found        = rq_rdata.found;
	assign status       = rq_rdata.status;
	assign bucket_index = rq_rdata.bidx;

endmodule

// ----- rtl/core/chb_ram.sv -----
// ----------------------------------------------------------------------------
// chb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module chb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/core/chb_fifo.sv -----
// ----------------------------------------------------------------------------
// chb_fifo
// Two-entry queue that decouples a producer from a consumer.
// ----------------------------------------------------------------------------
module chb_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wptr_q;
	logic             rptr_q;
	logic [1:0]       cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = slot_q[rptr_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wptr_q <= !wptr_q;
			end
			if (do_rd) begin
				rptr_q <= !rptr_q;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ----- rtl/core/chb_front.sv -----
// ----------------------------------------------------------------------------
// chb_front
// Accepts a beat, reduces the key modulo the bucket count eight bits a cycle
// and hands the classified beat to the work queue.
// ----------------------------------------------------------------------------
module chb_front import chb_pkg::*; #(
	parameter int MAX_BUCKETS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  op_t              operation,
	input  logic [KEY_W-1:0] key,
	input  logic [CFG_W-1:0] bucket_count,
	output logic             wq_wr,
	output work_t            wq_data,
	input  logic             wq_full
);

	logic             busy_q;
	logic             ready_q;
	logic [1:0]       cnt_q;
	logic [31:0]      sh_q;
	logic [CFG_W-1:0] rem_q;
	logic [CFG_W-1:0] div_q;
	op_t              op_q;
	logic [KEY_W-1:0] key_q;
	logic [CFG_W-1:0] div_d;
	logic [CFG_W-1:0] rem_d;

	// clamp the bucket count to 1..MAX_BUCKETS
	always_comb begin
		if (bucket_count == '0) begin
			div_d = CFG_W'(1);
		end else if ({4'b0, bucket_count} > 9'(MAX_BUCKETS)) begin
			div_d = CFG_W'(MAX_BUCKETS);
		end else begin
			div_d = bucket_count;
		end
	end

	// eight restoring remainder steps on the next key byte
	always_comb begin
		logic [CFG_W:0] t;
		rem_d = rem_q;
		for (int i = 0; i < 8; i++) begin
			t = {rem_d, sh_q[31-i]};
			if (t >= {1'b0, div_q}) begin
				t = t - {1'b0, div_q};
			end
			rem_d = t[CFG_W-1:0];
		end
	end

	assign full    = busy_q;
	assign wq_wr   = busy_q && ready_q;
	assign wq_data = '{op: op_q, key: key_q, rem: rem_q};

	always_ff @(posedge clk) begin
		if (push && !busy_q) begin
			sh_q  <= {1'b0, key};
			key_q <= key;
			op_q  <= operation;
			div_q <= div_d;
		end else if (busy_q && !ready_q) begin
			sh_q <= {sh_q[23:0], 8'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			ready_q <= 1'b0;
			cnt_q   <= 2'd0;
			rem_q   <= '0;
		end else begin
			if (!busy_q) begin
				if (push) begin
					busy_q  <= 1'b1;
					ready_q <= 1'b0;
					cnt_q   <= 2'd0;
					rem_q   <= '0;
				end
			end else if (!ready_q) begin
				rem_q <= rem_d;
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					ready_q <= 1'b1;
				end
			end else if (!wq_full) begin
				busy_q  <= 1'b0;
				ready_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/core/chb_back.sv -----
// ----------------------------------------------------------------------------
// chb_back
// Table engine: links inserted keys at the head of their chain and walks
// a chain one node per read for a search.
// ----------------------------------------------------------------------------
module chb_back import chb_pkg::*; #(
	parameter int MAX_BUCKETS  = 16,
	parameter int POOL_ENTRIES = 256
) (
	input  logic    clk,
	input  logic    arst_n,
	input  work_t   wq_data,
	input  logic    wq_empty,
	output logic    wq_rd,
	output logic    rq_wr,
	output result_t rq_data,
	input  logic    rq_full
);

	localparam int BW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int NW  = $clog2(POOL_ENTRIES);
	localparam int NDW = KEY_W + 1 + NW;

	back_state_t      st_q;
	back_state_t      st_d;
	op_t              op_q;
	logic [KEY_W-1:0] key_q;
	logic [CFG_W-1:0] rem_q;
	logic [BW-1:0]    bkt_q;
	logic             hv_q;
	logic             found_q;
	logic             status_q;
	logic [NW:0]      used_q;
	logic [MAX_BUCKETS-1:0] hvalid_q;

	logic [BW-1:0]    in_bkt;
	logic [8:0]       rem_ext;
	logic [NW-1:0]    head_rdata;
	logic             head_we;
	logic [NDW-1:0]   node_rdata;
	logic [NDW-1:0]   node_wdata;
	logic [NW-1:0]    node_raddr;
	logic             node_we;
	logic [KEY_W-1:0] rd_key;
	logic             rd_lnull;
	logic [NW-1:0]    rd_lidx;
	logic             pool_full;
	logic             take;
	logic             set_found;
	logic             set_status;

	assign rem_ext = {4'b0, wq_data.rem};
	assign in_bkt  = rem_ext[BW-1:0];

	assign rd_key   = node_rdata[NDW-1:NW+1];
	assign rd_lnull = node_rdata[NW];
	assign rd_lidx  = node_rdata[NW-1:0];

	assign pool_full  = (used_q == (NW+1)'(POOL_ENTRIES));
	assign node_wdata = {key_q, !hv_q, head_rdata};
	assign rq_data    = '{found: found_q, status: status_q, bidx: rem_q[BIDX_W-1:0]};

	chb_ram #(
		.WIDTH (NW),
		.DEPTH (MAX_BUCKETS)
	) u_head_ram (
		.clk   (clk),
		.we    (head_we),
		.waddr (bkt_q),
		.wdata (used_q[NW-1:0]),
		.raddr (in_bkt),
		.rdata (head_rdata)
	);

	chb_ram #(
		.WIDTH (NDW),
		.DEPTH (POOL_ENTRIES)
	) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (used_q[NW-1:0]),
		.wdata (node_wdata),
		.raddr (node_raddr),
		.rdata (node_rdata)
	);

	always_comb begin
		st_d       = st_q;
		take       = 1'b0;
		head_we    = 1'b0;
		node_we    = 1'b0;
		node_raddr = head_rdata;
		set_found  = 1'b0;
		set_status = 1'b0;
		rq_wr      = 1'b0;
		case (st_q)
			B_IDLE: begin
				if (!wq_empty) begin
					take = 1'b1;
					st_d = B_HEAD;
				end
			end
			B_HEAD: begin
				if (op_q == OP_INSERT) begin
					if (pool_full) begin
						set_status = 1'b1;
					end else begin
						node_we = 1'b1;
						head_we = 1'b1;
					end
					st_d = B_DONE;
				end else if (hv_q) begin
					st_d = B_WALK;
				end else begin
					st_d = B_DONE;
				end
			end
			B_WALK: begin
				node_raddr = rd_lidx;
				if (rd_key == key_q) begin
					set_found = 1'b1;
					st_d      = B_DONE;
				end else if (rd_lnull) begin
					st_d = B_DONE;
				end
			end
			B_DONE: begin
				rq_wr = 1'b1;
				if (!rq_full) begin
					st_d = B_IDLE;
				end
			end
			default: begin
				st_d = B_IDLE;
			end
		endcase
	end

	assign wq_rd = take;

	always_ff @(posedge clk) begin
		if (take) begin
			op_q  <= wq_data.op;
			key_q <= wq_data.key;
			rem_q <= wq_data.rem;
			bkt_q <= in_bkt;
			hv_q  <= hvalid_q[in_bkt];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= B_IDLE;
			found_q  <= 1'b0;
			status_q <= 1'b0;
			used_q   <= '0;
			hvalid_q <= '0;
		end else begin
			st_q <= st_d;
			if (take) begin
				found_q  <= 1'b0;
				status_q <= 1'b0;
			end
			if (set_found) begin
				found_q <= 1'b1;
			end
			if (set_status) begin
				status_q <= 1'b1;
			end
			if (head_we) begin
				hvalid_q[bkt_q] <= 1'b1;
				used_q          <= used_q + (NW+1)'(1);
			end
		end
	end

endmodule

// ----- tb/chained_hash_table_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_table_checker
// Watches the push, pop and bucket_count ports of the chained hash table, keeps
// its own copy of the bucket chains and node pool, works out the result of
// every accepted beat and compares each popped result field by field.
// ----------------------------------------------------------------------------
module chained_hash_table_checker import chb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              full,
	input  logic              operation,
	input  logic [KEY_W-1:0]  key,
	input  logic              empty,
	input  logic              pop,
	input  logic              found,
	input  logic              status,
	input  logic [BIDX_W-1:0] bucket_index,
	input  logic              bucket_count_we,
	input  logic [CFG_W-1:0]  bucket_count,
	output int                errors,
	output int                pending
);

	localparam int NBUCKETS = 16;
	localparam int NNODES   = 256;
	localparam logic [8:0] NO_NODE = 9'(NNODES);

	logic [CFG_W-1:0] buckets_cfg;
	logic [8:0]       head_of [NBUCKETS];
	logic [KEY_W-1:0] key_of  [NNODES];
	logic [8:0]       next_of [NNODES];
	int               nodes_taken;
	result_t          lookup_results_due [$];

	function automatic int unsigned buckets_in_use();
		int unsigned n;
		n = buckets_cfg;
		if (n == 0)
			n = 1;
		if (n > NBUCKETS)
			n = NBUCKETS;
		return n;
	endfunction

	task automatic apply_hash_op(input op_t op, input logic [KEY_W-1:0] k);
		result_t     r;
		int unsigned b;
		logic [8:0]  cur;
		int          steps;
		b = k % buckets_in_use();
		r.found  = 1'b0;
		r.status = 1'b0;
		r.bidx   = b[BIDX_W-1:0];
		if (op == OP_INSERT) begin
			if (nodes_taken >= NNODES) begin
				r.status = 1'b1;
			end else begin
				key_of[nodes_taken]  = k;
				next_of[nodes_taken] = head_of[b];
				head_of[b]           = 9'(nodes_taken);
				nodes_taken++;
			end
		end else begin
			cur   = head_of[b];
			steps = 0;
			while (cur < NNODES && steps < NNODES) begin
				if (key_of[cur] == k) begin
					r.found = 1'b1;
					break;
				end
				cur = next_of[cur];
				steps++;
			end
		end
		lookup_results_due.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			buckets_cfg = 5'd10;
			nodes_taken = 0;
			errors      = 0;
			foreach (head_of[i])
				head_of[i] = NO_NODE;
			lookup_results_due.delete();
		end else begin
			if (bucket_count_we)
				buckets_cfg = bucket_count;
			if (push && !full)
				apply_hash_op(op_t'(operation), key);
			if (pop && !empty) begin
				if (lookup_results_due.size() == 0) begin
					$display("%0t: result beat with none due: found %0b status %0b bucket %0d",
						$time, found, status, bucket_index);
					errors++;
				end else begin
					want = lookup_results_due.pop_front();
					if (found !== want.found) begin
						$display("%0t: found expected %0b actual %0b",
							$time, want.found, found);
						errors++;
					end
					if (status !== want.status) begin
						$display("%0t: status expected %0b actual %0b",
							$time, want.status, status);
						errors++;
					end
					if (bucket_index !== want.bidx) begin
						$display("%0t: bucket_index expected %0d actual %0d",
							$time, want.bidx, bucket_index);
						errors++;
					end
				end
			end
		end
		pending = lookup_results_due.size();
	end

endmodule

// ----- tb/chained_hash_table_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_table_tb
// Drives insert and search beats into the chained hash table across several
// bucket counts, filling the node pool until inserts are dropped, with random
// gaps on both queues; the checker beside the block scores every result.
// ----------------------------------------------------------------------------
module chained_hash_table_tb;
	import chb_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              push;
	logic              full;
	logic              operation;
	logic [KEY_W-1:0]  key;
	logic              empty;
	logic              pop;
	logic              found;
	logic              status;
	logic [BIDX_W-1:0] bucket_index;
	logic              bucket_count_we;
	logic [CFG_W-1:0]  bucket_count;
	int                errors;
	int                pending;

	logic [KEY_W-1:0]  inserted_keys [$];
	bit                push_steady;
	bit                pop_steady;

	chained_hash_table dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.operation       (operation),
		.key             (key),
		.empty           (empty),
		.pop             (pop),
		.found           (found),
		.status          (status),
		.bucket_index    (bucket_index),
		.bucket_count_we (bucket_count_we),
		.bucket_count    (bucket_count)
	);

	chained_hash_table_checker hash_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.operation       (operation),
		.key             (key),
		.empty           (empty),
		.pop             (pop),
		.found           (found),
		.status          (status),
		.bucket_index    (bucket_index),
		.bucket_count_we (bucket_count_we),
		.bucket_count    (bucket_count),
		.errors          (errors),
		.pending         (pending)
	);

	always #5 clk = ~clk;

	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end

	// result side: random pop gaps, with steady stretches
	initial begin
		int gap;
		pop = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				pop_steady = ~pop_steady;
			gap = pop_steady ? 0 : $urandom_range(0, 18);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			@(negedge clk);
		end
	end

	task automatic send_beat(input op_t op, input logic [KEY_W-1:0] k);
		int gap;
		if ($urandom_range(0, 39) == 0)
			push_steady = ~push_steady;
		gap = push_steady ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push      <= 1'b1;
		operation <= op;
		key       <= k;
		if (op == OP_INSERT)
			inserted_keys.push_back(k);
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	task automatic set_buckets(input logic [CFG_W-1:0] v);
		push <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
		bucket_count_we <= 1'b1;
		bucket_count    <= v;
		@(negedge clk);
		bucket_count_we <= 1'b0;
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3, 4: return KEY_W'($urandom_range(0, 40));
			default: return KEY_W'($urandom());
		endcase
	endfunction

	function automatic logic [KEY_W-1:0] pick_search_key();
		if (inserted_keys.size() > 0 && $urandom_range(0, 9) < 6)
			return inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
		return pick_key();
	endfunction

	initial begin
		logic [CFG_W-1:0] phase_counts [12];
		clk             = 1'b0;
		arst_n          = 1'b0;
		push            = 1'b0;
		operation       = 1'b0;
		key             = '0;
		bucket_count_we = 1'b0;
		bucket_count    = '0;
		push_steady     = 1'b0;
		pop_steady      = 1'b0;
		phase_counts    = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd7,
			5'd3, 5'd13, 5'd2, 5'd16, 5'd1, 5'd5};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset bucket count of ten, empty table first
		send_beat(OP_SEARCH, '0);
		send_beat(OP_INSERT, '0);
		send_beat(OP_INSERT, '1);
		send_beat(OP_INSERT, 31'd10);
		send_beat(OP_INSERT, '0);
		send_beat(OP_SEARCH, '0);
		send_beat(OP_SEARCH, '1);
		send_beat(OP_SEARCH, 31'd10);
		send_beat(OP_SEARCH, 31'd20);
		send_beat(OP_INSERT, 31'd5);
		send_beat(OP_SEARCH, 31'd5);
		send_beat(OP_SEARCH, 31'h5555_5555);
		send_beat(OP_INSERT, 31'h2AAA_AAAA);
		send_beat(OP_SEARCH, 31'h2AAA_AAAA);

		// zero count acts as one bucket, older chains stay put
		set_buckets(5'd0);
		send_beat(OP_SEARCH, '0);
		send_beat(OP_SEARCH, 31'd10);
		send_beat(OP_SEARCH, '1);
		send_beat(OP_INSERT, 31'd3);
		send_beat(OP_SEARCH, 31'd3);

		// count above the maximum saturates
		set_buckets(5'd31);
		send_beat(OP_SEARCH, '1);
		send_beat(OP_INSERT, 31'd17);
		send_beat(OP_SEARCH, 31'd17);

		foreach (phase_counts[p]) begin
			set_buckets(phase_counts[p]);
			repeat (110) begin
				if ($urandom_range(0, 9) < 3)
					send_beat(OP_INSERT, pick_key());
				else
					send_beat(OP_SEARCH, pick_search_key());
			end
		end

		push <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
